// ===== rtl/core/pfa_pkg.sv =====
// shared types, codes and constants for the page frame allocator
package pfa_pkg;

  localparam int FRAMES_DEF = 64;
  localparam int FRAME_W    = 6;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int POLICY_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EVICT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_NOFREE   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOEVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOPOLICY = 3'd3;
  localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd4;

  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU  = 2'd1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_REMOVE,
    OP_APPEND
  } pfa_op_t;

  typedef struct packed {
    logic valid;
    logic seen;
  } pfa_link_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_TOUCH
  } pfa_state_t;

endpackage

// ===== rtl/core/page_frame_allocator_replacer_top.sv =====
// Page frame allocator with a circular free-frame queue in RAM and a FIFO/LRU order list
// held in a chain of cells, oldest frame at the head. After reset the block loads frames
// 0 to FRAMES-1 into the free queue and accepts no transaction until that is done;
// policy writes are taken at any time the block is idle. Allocate, evict, free and
// touch outside LRU pass from the idle state, where they are accepted, to the execute
// state, where the queue and chain are updated and the result is registered once the
// output register is free. A touch under LRU goes on from there to the touch state,
// where the chain drops one copy of the frame per cycle and then appends the frame.
// A finished result sits in an output register; the next transaction is accepted while it
// waits, and execution stalls only when a new result is ready and the previous one has
// not been taken.
module page_frame_allocator_replacer_top #(
  parameter int FRAMES = pfa_pkg::FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pfa_pkg::POLICY_W-1:0]     cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pfa_pkg::CMD_W-1:0]        in_command,
  input  logic [pfa_pkg::FRAME_W-1:0]      in_frame,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pfa_pkg::FRAME_W-1:0]      out_frame_out,
  output logic [pfa_pkg::STATUS_W-1:0]     out_status,
  output logic                             out_full_res
);

  localparam int AW = $clog2(FRAMES);
  localparam int EW = AW;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int SW = AW + 1;
  localparam int XW = (EW > pfa_pkg::FRAME_W) ? EW : pfa_pkg::FRAME_W;

  pfa_pkg::pfa_state_t state_r, state_nxt;

  logic [pfa_pkg::POLICY_W-1:0] policy_r;
  logic [AW-1:0]                init_r, init_nxt;
  logic [AW-1:0]                head_r, head_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [pfa_pkg::CMD_W-1:0]    cmd_r;
  logic [pfa_pkg::FRAME_W-1:0]  frame_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [pfa_pkg::FRAME_W-1:0]  out_frame_r, out_frame_nxt;
  logic [pfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                         out_full_r, out_full_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [EW-1:0]                ram_rdata;

  pfa_pkg::pfa_op_t             op;
  logic [EW-1:0]                key;
  logic [EW-1:0]                chain_head;
  logic                         chain_empty, chain_full, chain_match;

  logic                         accept, out_free, out_load, tracked, frame_ok;
  logic                         q_full, q_empty;
  logic [EW-1:0]                frame_e, fout_e;
  logic [XW-1:0]                frame_x, fout_x;
  logic [SW-1:0]                tail_sum;
  logic [AW-1:0]                tail;
  logic [AW-1:0]                head_inc;
  logic [pfa_pkg::STATUS_W-1:0] status;

  pfa_ram #(
    .WIDTH(EW),
    .DEPTH(FRAMES)
  ) u_free_q (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  pfa_order_chain #(
    .FRAMES(FRAMES),
    .EW    (EW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .key      (key),
    .head_data(chain_head),
    .empty    (chain_empty),
    .full     (chain_full),
    .any_match(chain_match)
  );

  always_comb begin
    frame_x  = XW'(frame_r);
    frame_e  = frame_x[EW-1:0];
    // allocate appends the head of the free queue, everything else uses the frame field
    key      = ((state_r == pfa_pkg::S_EXEC) && (cmd_r == pfa_pkg::CMD_ALLOC)) ?
               ram_rdata : frame_e;
    frame_ok = int'(frame_r) < FRAMES;
    tracked  = (policy_r == pfa_pkg::POL_FIFO) || (policy_r == pfa_pkg::POL_LRU);
    q_full   = count_r == CW'(FRAMES);
    q_empty  = count_r == '0;
    // tail = (head + count) mod FRAMES, the sum stays below twice FRAMES
    tail_sum = SW'(head_r) + SW'(count_r);
    if (tail_sum >= SW'(FRAMES)) begin
      tail_sum = tail_sum - SW'(FRAMES);
    end
    tail     = tail_sum[AW-1:0];
    head_inc = (head_r == AW'(FRAMES - 1)) ? '0 : head_r + AW'(1);
    out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = frame_e;
    op        = pfa_pkg::OP_HOLD;
    out_load  = 1'b0;
    fout_e    = '0;
    status    = pfa_pkg::STS_OK;

    case (state_r)
      pfa_pkg::S_INIT: begin
        // clearing pass loads frame i into queue slot i
        ram_we    = 1'b1;
        ram_waddr = init_r;
        ram_wdata = init_r;
        init_nxt  = init_r + AW'(1);
        if (init_r == AW'(FRAMES - 1)) begin
          state_nxt = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = pfa_pkg::S_EXEC;
        end
      end
      pfa_pkg::S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pfa_pkg::S_IDLE;
          case (cmd_r)
            pfa_pkg::CMD_ALLOC: begin
              if (q_empty) begin
                status = pfa_pkg::STS_NOFREE;
              end else begin
                fout_e    = ram_rdata;
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
                if (tracked) begin
                  if (chain_full) begin
                    status = pfa_pkg::STS_OVERFLOW;
                  end else begin
                    op = pfa_pkg::OP_APPEND;
                  end
                end
              end
            end
            pfa_pkg::CMD_EVICT: begin
              if (!tracked) begin
                status = pfa_pkg::STS_NOPOLICY;
              end else if (chain_empty) begin
                status = pfa_pkg::STS_NOEVICT;
              end else begin
                fout_e    = chain_head;
                op        = pfa_pkg::OP_SHIFT;
                ram_wdata = chain_head;
                if (q_full) begin
                  status = pfa_pkg::STS_OVERFLOW;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            pfa_pkg::CMD_TOUCH: begin
              if ((policy_r == pfa_pkg::POL_LRU) && frame_ok) begin
                out_load  = 1'b0;
                state_nxt = pfa_pkg::S_TOUCH;
              end
            end
            pfa_pkg::CMD_FREE: begin
              if (frame_ok) begin
                if (q_full) begin
                  status = pfa_pkg::STS_OVERFLOW;
                end else begin
                  ram_we    = 1'b1;
                  count_nxt = count_r + CW'(1);
                end
              end
            end
            default: begin
              status = pfa_pkg::STS_OK;
            end
          endcase
        end
      end
      pfa_pkg::S_TOUCH: begin
        // one copy leaves the chain per cycle, then the frame goes to the back
        if (chain_match) begin
          op = pfa_pkg::OP_REMOVE;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = pfa_pkg::S_IDLE;
          if (chain_full) begin
            status = pfa_pkg::STS_OVERFLOW;
          end else begin
            op = pfa_pkg::OP_APPEND;
          end
        end
      end
      default: begin
        state_nxt = pfa_pkg::S_IDLE;
      end
    endcase

    accept = in_valid && in_ready;

    fout_x         = XW'(fout_e);
    out_frame_nxt  = out_load ? fout_x[pfa_pkg::FRAME_W-1:0] : out_frame_r;
    out_status_nxt = out_load ? status : out_status_r;
    out_full_nxt   = out_load ? (count_nxt == '0) : out_full_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::S_INIT;
      init_r      <= '0;
      head_r      <= '0;
      count_r     <= CW'(FRAMES);
      policy_r    <= pfa_pkg::POL_FIFO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      frame_r <= in_frame;
    end
    out_frame_r  <= out_frame_nxt;
    out_status_r <= out_status_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_frame_out = out_frame_r;
  assign out_status    = out_status_r;
  assign out_full_res  = out_full_r;

endmodule

// ===== rtl/core/pfa_ram.sv =====
// generic single write port ram with registered read
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pfa_cell.sv =====
// one entry of the replacement order chain
module pfa_cell #(
  parameter int EW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pfa_pkg::pfa_op_t   op,
  input  logic [EW-1:0]      key,
  input  pfa_pkg::pfa_link_t left_i,
  input  logic               right_valid_i,
  input  logic [EW-1:0]      right_data_i,
  output pfa_pkg::pfa_link_t link_o,
  output logic [EW-1:0]      data_o
);

  logic          valid_r, valid_nxt;
  logic [EW-1:0] data_r, data_nxt;
  logic          match, seen, take, load;

  always_comb begin
    match = valid_r && (data_r == key);
    seen  = left_i.seen || match;
    // shift-all for evict, shift from the first copy onward for touch removal
    take  = (op == pfa_pkg::OP_SHIFT) || ((op == pfa_pkg::OP_REMOVE) && seen);
    // first empty slot takes the appended frame
    load  = (op == pfa_pkg::OP_APPEND) && !valid_r && left_i.valid;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (take) begin
      valid_nxt = right_valid_i;
      data_nxt  = right_data_i;
    end else if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link_o.valid = valid_r;
  assign link_o.seen  = seen;
  assign data_o       = data_r;

endmodule

// ===== rtl/core/pfa_order_chain.sv =====
// replacement order list as a row of cells, oldest at cell zero
module pfa_order_chain #(
  parameter int FRAMES = pfa_pkg::FRAMES_DEF,
  parameter int EW     = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pfa_pkg::pfa_op_t op,
  input  logic [EW-1:0]    key,
  output logic [EW-1:0]    head_data,
  output logic             empty,
  output logic             full,
  output logic             any_match
);

  pfa_pkg::pfa_link_t link [FRAMES];
  logic [EW-1:0]      data [FRAMES];

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    pfa_pkg::pfa_link_t left;
    logic               rvalid;
    logic [EW-1:0]      rdata;

    if (i == 0) begin : g_first
      assign left.valid = 1'b1;
      assign left.seen  = 1'b0;
    end else begin : g_mid
      assign left = link[i-1];
    end

    if (i == FRAMES - 1) begin : g_last
      assign rvalid = 1'b0;
      assign rdata  = '0;
    end else begin : g_inner
      assign rvalid = link[i+1].valid;
      assign rdata  = data[i+1];
    end

    pfa_cell #(
      .EW(EW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .key          (key),
      .left_i       (left),
      .right_valid_i(rvalid),
      .right_data_i (rdata),
      .link_o       (link[i]),
      .data_o       (data[i])
    );
  end

  assign head_data = data[0];
  assign empty     = !link[0].valid;
  assign full      = link[FRAMES-1].valid;
  assign any_match = link[FRAMES-1].seen;

endmodule

// ===== test/page_frame_allocator_replacer_top_tb.sv =====
// self-checking testbench for the page frame allocator with fifo/lru replacement
`timescale 1ns / 1ps

module page_frame_allocator_replacer_top_tb;

  localparam int FRAMES = pfa_pkg::FRAMES_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;
  localparam logic [pfa_pkg::POLICY_W-1:0] POL_NONE     = 2'd2;
  localparam logic [pfa_pkg::POLICY_W-1:0] POL_NONE_ALT = 2'd3;

  typedef struct packed {
    logic [pfa_pkg::CMD_W-1:0]   cmd;
    logic [pfa_pkg::FRAME_W-1:0] frame;
  } frame_cmd_t;

  typedef struct packed {
    logic [pfa_pkg::FRAME_W-1:0]  frame_out;
    logic [pfa_pkg::STATUS_W-1:0] status;
    logic                         full_res;
  } frame_reply_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_TOUCH, MIX_FREE, MIX_ANY} cmd_mix_t;
  typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pace_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [pfa_pkg::POLICY_W-1:0] cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [pfa_pkg::CMD_W-1:0]    in_command = '0;
  logic [pfa_pkg::FRAME_W-1:0]  in_frame = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [pfa_pkg::FRAME_W-1:0]  out_frame_out;
  logic [pfa_pkg::STATUS_W-1:0] out_status;
  logic                         out_full_res;

  // predictor state
  logic [pfa_pkg::POLICY_W-1:0] model_policy;
  logic [pfa_pkg::FRAME_W-1:0]  free_ring [FRAMES];
  int                           ring_head;
  int                           ring_count;
  logic [pfa_pkg::FRAME_W-1:0]  recency_order [$];

  frame_cmd_t   pending_cmds [$];
  frame_reply_t predicted_replies [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           long_stall_req = 0;

  // driver, receiver and monitor locals
  int           burst_left = 0;
  int           gap_left = 0;
  frame_cmd_t   next_cmd;
  int           stall_ack = 0;
  int           hold_left = 0;
  int           pace_left = 0;
  rx_pace_t     rx_pace = RX_FREE;
  frame_reply_t want;

  page_frame_allocator_replacer_top #(.FRAMES(FRAMES)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_frame     (in_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_frame_out(out_frame_out),
    .out_status   (out_status),
    .out_full_res (out_full_res)
  );

  always #10 clk = ~clk;

  function automatic bit ring_push(input logic [pfa_pkg::FRAME_W-1:0] f);
    if (ring_count >= FRAMES) return 1'b0;
    free_ring[(ring_head + ring_count) % FRAMES] = f;
    ring_count++;
    return 1'b1;
  endfunction

  function automatic frame_reply_t allocator_step(input logic [pfa_pkg::CMD_W-1:0] cmd,
                                                  input logic [pfa_pkg::FRAME_W-1:0] frame);
    frame_reply_t                r;
    logic [pfa_pkg::FRAME_W-1:0] kept [$];
    bit                          tracked;
    r = '0;
    r.status = pfa_pkg::STS_OK;
    tracked = (model_policy == pfa_pkg::POL_FIFO) || (model_policy == pfa_pkg::POL_LRU);
    case (cmd)
      pfa_pkg::CMD_ALLOC: begin
        if (ring_count == 0) begin
          r.status = pfa_pkg::STS_NOFREE;
        end else begin
          r.frame_out = free_ring[ring_head];
          ring_head = (ring_head + 1) % FRAMES;
          ring_count--;
          if (tracked) begin
            if (recency_order.size() < FRAMES)
              recency_order.insert(recency_order.size(), r.frame_out);
            else r.status = pfa_pkg::STS_OVERFLOW;
          end
        end
      end
      pfa_pkg::CMD_EVICT: begin
        if (!tracked) begin
          r.status = pfa_pkg::STS_NOPOLICY;
        end else if (recency_order.size() == 0) begin
          r.status = pfa_pkg::STS_NOEVICT;
        end else begin
          r.frame_out = recency_order[0];
          recency_order.delete(0);
          if (!ring_push(r.frame_out)) r.status = pfa_pkg::STS_OVERFLOW;
        end
      end
      pfa_pkg::CMD_TOUCH: begin
        if (model_policy == pfa_pkg::POL_LRU && frame < FRAMES) begin
          // drop every copy, then move to the most recent end
          foreach (recency_order[i]) begin
            if (recency_order[i] != frame) kept.insert(kept.size(), recency_order[i]);
          end
          recency_order = kept;
          if (recency_order.size() < FRAMES)
            recency_order.insert(recency_order.size(), frame);
          else r.status = pfa_pkg::STS_OVERFLOW;
        end
      end
      default: begin
        if (frame < FRAMES && !ring_push(frame)) r.status = pfa_pkg::STS_OVERFLOW;
      end
    endcase
    r.full_res = (ring_count == 0);
    return r;
  endfunction

  function automatic logic [pfa_pkg::CMD_W-1:0] pick_command(input cmd_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  return pfa_pkg::CMD_ALLOC;
      MIX_DRAIN: return (r < 80) ? pfa_pkg::CMD_EVICT : pfa_pkg::CMD_ALLOC;
      MIX_TOUCH: return (r < 60) ? pfa_pkg::CMD_TOUCH : (r < 75) ? pfa_pkg::CMD_ALLOC :
                        (r < 90) ? pfa_pkg::CMD_EVICT : pfa_pkg::CMD_FREE;
      MIX_FREE:  return (r < 50) ? pfa_pkg::CMD_FREE :
                        (r < 80) ? pfa_pkg::CMD_ALLOC : pfa_pkg::CMD_EVICT;
      default:   return pfa_pkg::CMD_W'($urandom_range(0, 3));
    endcase
  endfunction

  // a small pool of frame numbers makes duplicates and touch hits common
  function automatic logic [pfa_pkg::FRAME_W-1:0] pick_frame();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return pfa_pkg::FRAME_W'($urandom_range(0, 7));
    if (r == 5) return '0;
    if (r == 6) return '1;
    return pfa_pkg::FRAME_W'($urandom_range(0, FRAMES - 1));
  endfunction

  task automatic queue_cmd(input logic [pfa_pkg::CMD_W-1:0] cmd,
                           input logic [pfa_pkg::FRAME_W-1:0] frame);
    frame_cmd_t c;
    c.cmd = cmd;
    c.frame = frame;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic queue_random(input int count);
    int       left;
    int       seg;
    cmd_mix_t mix;
    left = count;
    while (left > 0) begin
      seg = $urandom_range(8, 70);
      if (seg > left) seg = left;
      mix = cmd_mix_t'($urandom_range(0, 4));
      repeat (seg) queue_cmd(pick_command(mix), pick_frame());
      left -= seg;
    end
  endtask

  // sample after the edge has settled so a just-popped transaction is not missed
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_cmds.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_policy(input logic [pfa_pkg::POLICY_W-1:0] p);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    model_policy = p;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: one transaction per accept, in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        predicted_replies.insert(predicted_replies.size(),
                                 allocator_step(in_command, in_frame));
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          in_valid <= 1'b1;
          in_command <= next_cmd.cmd;
          in_frame <= next_cmd.frame;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: pace changes per segment, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_ack != long_stall_req) begin
        stall_ack = long_stall_req;
        hold_left = LONG_HOLD;
      end
      if (pace_left == 0) begin
        pace_left = $urandom_range(10, 120);
        rx_pace = rx_pace_t'($urandom_range(0, 3));
      end else begin
        pace_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_pace)
          RX_FREE:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected result frame_out=%0d status=%0d full_res=%0d",
                 $time, out_frame_out, out_status, out_full_res);
        mismatch_count++;
      end else begin
        want = predicted_replies[0];
        predicted_replies.delete(0);
        if (out_frame_out !== want.frame_out) begin
          $display("%0t: frame_out expected %0d actual %0d", $time, want.frame_out,
                   out_frame_out);
          mismatch_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_full_res !== want.full_res) begin
          $display("%0t: full_res expected %0d actual %0d", $time, want.full_res,
                   out_full_res);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [pfa_pkg::POLICY_W-1:0] p;
    model_policy = pfa_pkg::POL_FIFO;
    for (int i = 0; i < FRAMES; i++) free_ring[i] = pfa_pkg::FRAME_W'(i);
    ring_head = 0;
    ring_count = FRAMES;
    recency_order.delete();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // the block loads its free queue before it takes anything
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    set_policy(pfa_pkg::POL_FIFO);
    queue_cmd(pfa_pkg::CMD_FREE, '1);       // free queue still full
    queue_cmd(pfa_pkg::CMD_EVICT, '0);      // nothing to evict
    queue_cmd(pfa_pkg::CMD_TOUCH, '1);      // touch ignored outside lru
    queue_cmd(pfa_pkg::CMD_ALLOC, '0);
    queue_cmd(pfa_pkg::CMD_ALLOC, '1);
    queue_cmd(pfa_pkg::CMD_EVICT, '0);
    queue_cmd(pfa_pkg::CMD_FREE, '0);
    wait_drained();

    set_policy(POL_NONE);
    queue_cmd(pfa_pkg::CMD_ALLOC, '0);      // taken but not tracked
    queue_cmd(pfa_pkg::CMD_EVICT, '0);
    queue_cmd(pfa_pkg::CMD_TOUCH, '0);
    wait_drained();

    set_policy(POL_NONE_ALT);
    queue_cmd(pfa_pkg::CMD_EVICT, '1);
    queue_cmd(pfa_pkg::CMD_ALLOC, '1);
    wait_drained();

    set_policy(pfa_pkg::POL_LRU);
    queue_cmd(pfa_pkg::CMD_TOUCH, '1);      // absent frame gets appended
    queue_cmd(pfa_pkg::CMD_TOUCH, 6'd5);
    queue_cmd(pfa_pkg::CMD_TOUCH, '1);
    queue_cmd(pfa_pkg::CMD_ALLOC, '0);
    queue_cmd(pfa_pkg::CMD_TOUCH, 6'd1);
    queue_cmd(pfa_pkg::CMD_EVICT, '0);
    queue_cmd(pfa_pkg::CMD_EVICT, '0);
    queue_cmd(pfa_pkg::CMD_EVICT, '0);      // free queue may be full here
    queue_cmd(pfa_pkg::CMD_FREE, '1);
    queue_cmd(pfa_pkg::CMD_FREE, '1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 6:    p = pfa_pkg::POL_FIFO;
        3:       p = POL_NONE;
        5:       p = POL_NONE_ALT;
        default: p = pfa_pkg::POL_LRU;
      endcase
      set_policy(p);
      // run the free queue dry and fill the order list
      if (ph == 0 || ph == 4) repeat (70) queue_cmd(pfa_pkg::CMD_ALLOC, pick_frame());
      if (ph == 2) long_stall_req++;
      queue_random(100);
      wait_drained();
      queue_random(100);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
